### rtl/mbbc_pkg.sv
// Package of shared types and constants for the mixed byte block checksum.
package mbbc_pkg;

   localparam int MAX_BYTES = 1024;
   localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);
   localparam int SUM_W     = 17;

   localparam logic [7:0] BYTE_INVERT = 8'hFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] checksum;
      logic             too_long;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic valid;
      logic last;
   } term_ctrl_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MID   = 5'b00010,
      S_MIX   = 5'b00100,
      S_WALK  = 5'b01000,
      S_DRAIN = 5'b10000
   } state_type;

endpackage

### rtl/mbbc_term_unit.sv
// Shared term unit: forms one mixed term per cycle and folds it into the accumulator.
module mbbc_term_unit
   import mbbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  term_ctrl_type    ctrl,
   input  logic [7:0]       rd_byte,
   input  logic [7:0]       rd_index,
   input  logic [7:0]       mixer,
   input  logic [7:0]       mid,
   input  logic [7:0]       last_val,
   output logic             done,
   output logic [SUM_W-1:0] sum
);

   logic [SUM_W-1:0] term_ff;
   logic [SUM_W-1:0] term_in;
   logic             term_vld_ff;
   logic             term_last_ff;
   logic [SUM_W-1:0] acc_ff;
   logic [SUM_W-1:0] acc_in;
   logic [8:0]       base;

   always_comb begin
      base    = {1'b0, rd_byte ^ mixer} + {1'b0, mid};
      term_in = SUM_W'(base) * SUM_W'(last_val) + SUM_W'(rd_index);
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (term_vld_ff) begin
         acc_in = acc_ff ^ term_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_vld_ff  <= 1'b0;
         term_last_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         term_vld_ff  <= ctrl.valid;
         term_last_ff <= ctrl.valid & ctrl.last;
         acc_ff       <= acc_in;
      end
      term_ff <= term_in;
   end

   assign done = term_vld_ff & term_last_ff;
   assign sum  = acc_ff ^ term_ff;

endmodule

### rtl/mixed_byte_block_checksum.sv
// Top level of the mixed byte block checksum: byte store, sequencer and result register.
//
// The block takes the bytes of a memory block, one request per byte, on req_data while
// start is high and busy is low; last_byte marks the final byte. Bytes are written into
// an internal store of MAX_BYTES entries, one per cycle, so loading runs at one byte a
// cycle with busy low throughout.
// After the final byte one result appears on rsp_data for a single cycle with rsp_valid
// high. A one-byte block, or a block longer than the store, answers in the cycle after
// its final byte and leaves busy low. Any other block holds busy high while it is
// computed and answers in the same cycle that busy falls: the sequencer reads the middle
// byte, then walks the store once through its single read port, one byte a cycle,
// feeding a shared term unit with one multiplier and the accumulator.
// A block longer than the store returns too_long set and a zero checksum.
// Synchronous reset returns the sequencer to idle and clears the byte count and the
// overflow flag; the store contents are left as they are and need no clearing.
// The receiver cannot stall: every result must be taken in the cycle it is shown.
module mixed_byte_block_checksum
   import mbbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic [7:0]       store [MAX_BYTES];
   logic [7:0]       rd_data_ff;
   logic             mem_wr;
   logic [ADDR_W-1:0] rd_addr;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       first_ff, first_in;
   logic [7:0]       lastv_ff, lastv_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] walk_ff, walk_in;
   logic [7:0]       mid_ff, mid_in;
   logic [7:0]       mixer_ff, mixer_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_last_ff, rd_last_in;
   logic [7:0]       rd_idx_ff, rd_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             stored;
   logic             walk_end;
   term_ctrl_type    term_ctrl;
   logic             term_done;
   logic [SUM_W-1:0] term_sum;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start & ~busy;
   assign stored   = (count_ff < CNT_W'(MAX_BYTES));
   assign walk_end = (walk_ff == (len_ff - CNT_W'(1)));

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      first_in        = first_ff;
      lastv_in        = lastv_ff;
      len_in          = len_ff;
      walk_in         = walk_ff;
      mid_in          = mid_ff;
      mixer_in        = mixer_ff;
      rsp_valid_in    = 1'b0;
      rsp_data_in     = rsp_data_ff;
      mem_wr          = 1'b0;
      rd_addr         = walk_ff[ADDR_W-1:0];
      term_ctrl.clear = 1'b0;
      term_ctrl.valid = rd_vld_ff;
      term_ctrl.last  = rd_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mem_wr = stored;
               if (count_ff == '0) begin
                  first_in = req_data.data_byte;
               end
               lastv_in = req_data.data_byte;
               if (!req_data.last_byte) begin
                  if (stored) begin
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  if (ovf_ff || !stored) begin
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.checksum = '0;
                     rsp_data_in.too_long = 1'b1;
                  end else if (count_ff == '0) begin
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.checksum = SUM_W'(req_data.data_byte ^ BYTE_INVERT);
                     rsp_data_in.too_long = 1'b0;
                  end else begin
                     len_in   = count_ff + CNT_W'(1);
                     state_in = S_MID;
                  end
               end
            end
         end
         S_MID: begin
            rd_addr  = ADDR_W'(len_ff >> 1);
            state_in = S_MIX;
         end
         S_MIX: begin
            mid_in          = rd_data_ff;
            mixer_in        = ~(first_ff ^ lastv_ff) ^ rd_data_ff;
            term_ctrl.clear = 1'b1;
            walk_in         = '0;
            state_in        = S_WALK;
         end
         S_WALK: begin
            walk_in = walk_ff + CNT_W'(1);
            if (walk_end) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (term_done) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.checksum = term_sum;
               rsp_data_in.too_long = 1'b0;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rd_vld_in  = (state_ff == S_WALK);
      rd_last_in = walk_end;
      rd_idx_in  = 8'(walk_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         store[count_ff[ADDR_W-1:0]] <= req_data.data_byte;
      end
      rd_data_ff <= store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff    <= first_in;
      lastv_ff    <= lastv_in;
      len_ff      <= len_in;
      walk_ff     <= walk_in;
      mid_ff      <= mid_in;
      mixer_ff    <= mixer_in;
      rd_last_ff  <= rd_last_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   mbbc_term_unit u_term (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (term_ctrl),
      .rd_byte  (rd_data_ff),
      .rd_index (rd_idx_ff),
      .mixer    (mixer_ff),
      .mid      (mid_ff),
      .last_val (lastv_ff),
      .done     (term_done),
      .sum      (term_sum)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An overlong block must report a zero checksum.
   a_too_long_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.too_long |-> rsp_data.checksum == '0)
      else $error("too_long result with non-zero checksum");

   // The compute pass only starts on the final byte of a block.
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_data.last_byte))
      else $error("busy raised without a final byte");

   // The final term of the walk arrives only while draining.
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      term_done |-> state_ff == S_DRAIN)
      else $error("term unit finished outside the drain state");

   // Leaving the drain state always produces a result.
   a_drain_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN && state_in == S_IDLE |=> rsp_valid)
      else $error("drain finished without a result");

endmodule

### dv/mixed_byte_block_checksum_tb.sv
// Self-checking testbench for the mixed byte block checksum, with its own checksum predictor.
module mixed_byte_block_checksum_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mbbc_pkg::*;

   localparam int QUIET_LIMIT = 4 * (MAX_BYTES + 16);
   localparam int TAIL_CYCLES = 20;
   localparam int RANDOM_BYTES = 650;

   typedef enum {FILL_RANDOM, FILL_SAME, FILL_EDGE} fill_type;

   typedef bit [7:0] byte_list_type[$];

   typedef struct {
      req_type     req;
      int unsigned gap;
      bit          pause;
   } pending_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   pending_type byte_q[$];
   rsp_type     checksum_q[$];
   pending_type next_byte;
   int unsigned idle_left = 0;
   bit          req_taken = 1'b0;
   int unsigned quiet_cycles = 0;
   bit          stalled = 1'b0;
   int unsigned mismatches = 0;
   int unsigned bytes_queued = 0;

   bit [7:0]    held_bytes[MAX_BYTES];
   int unsigned held_count = 0;
   bit          overflowed = 1'b0;

   mixed_byte_block_checksum dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stores one byte and, on the final byte of a block, works out its checksum.
   function automatic bit take_byte(input req_type r, output rsp_type sum_out);
      int unsigned first_i, mid_i, last_i, mixer_i, term, acc;
      bit [7:0]    mixed;
      sum_out = '0;
      if (held_count < MAX_BYTES) begin
         held_bytes[held_count] = r.data_byte;
         held_count++;
      end else begin
         overflowed = 1'b1;
      end
      if (!r.last_byte) return 1'b0;
      if (overflowed) begin
         sum_out.too_long = 1'b1;
      end else if (held_count == 1) begin
         sum_out.checksum = SUM_W'(held_bytes[0] ^ BYTE_INVERT);
      end else begin
         first_i = held_bytes[0];
         last_i  = held_bytes[held_count - 1];
         mid_i   = held_bytes[held_count / 2];
         mixer_i = (~(first_i ^ last_i) ^ mid_i) & 32'hFF;
         acc = 0;
         for (int unsigned i = 0; i < held_count; i++) begin
            mixed = held_bytes[i] ^ mixer_i[7:0];
            term  = (int'(mixed) + mid_i) * last_i + (i & 32'hFF);
            acc   = (acc ^ term) & 32'h1FFFF;
         end
         sum_out.checksum = acc[SUM_W-1:0];
      end
      held_count = 0;
      overflowed = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch on %s at %0t: got %0h, expected %0h", field, $time, got, want);
      mismatches++;
   endtask

   task automatic add_byte(input bit [7:0] value, input bit is_last, input bit idle_on);
      pending_type p;
      p.req.data_byte = value;
      p.req.last_byte = is_last;
      p.gap   = idle_on ? $urandom_range(0, 10) : 0;
      p.pause = 1'b0;
      byte_q.push_back(p);
      bytes_queued++;
   endtask

   task automatic add_pause();
      pending_type p;
      p.req   = '0;
      p.gap   = 0;
      p.pause = 1'b1;
      byte_q.push_back(p);
   endtask

   task automatic add_directed(input byte_list_type values);
      foreach (values[i]) add_byte(values[i], i == values.size() - 1, 1'b0);
   endtask

   task automatic add_block(input int unsigned len, input fill_type fill, input bit idle_on);
      bit [7:0] same_value;
      bit [7:0] value;
      same_value = $urandom_range(0, 255);
      for (int unsigned i = 0; i < len; i++) begin
         case (fill)
            FILL_SAME: value = same_value;
            FILL_EDGE: value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:   value = $urandom_range(0, 255);
         endcase
         add_byte(value, i == len - 1, idle_on);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         start <= 1'b1;
      end else if (idle_left != 0) begin
         start <= 1'b0;
         idle_left = idle_left - 1;
      end else if (byte_q.size() != 0 && byte_q[0].pause) begin
         start <= 1'b0;
         if (checksum_q.size() == 0) void'(byte_q.pop_front());
      end else if (byte_q.size() != 0) begin
         next_byte = byte_q.pop_front();
         start    <= 1'b1;
         req_data <= next_byte.req;
         idle_left = next_byte.gap;
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type predicted;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid) begin
            if (checksum_q.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_data.checksum), 0);
            end else begin
               want = checksum_q.pop_front();
               if (rsp_data.checksum !== want.checksum)
                  report_mismatch("checksum", 32'(rsp_data.checksum), 32'(want.checksum));
               if (rsp_data.too_long !== want.too_long)
                  report_mismatch("too_long", 32'(rsp_data.too_long), 32'(want.too_long));
            end
         end
         if (start && !busy) begin
            req_taken = 1'b1;
            if (take_byte(req_data, predicted)) checksum_q.push_back(predicted);
         end
         if (req_taken || rsp_valid) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) stalled = 1'b1;
         end
      end
   end

   initial begin
      int unsigned len;
      int unsigned pick;
      bit          idle_on;
      fill_type    fill;

      add_directed('{8'h00});
      add_directed('{8'hFF});
      add_directed('{8'hFF, 8'hFF});
      add_directed('{8'h00, 8'h00});
      add_directed('{8'h00, 8'hFF});
      add_directed('{8'hFF, 8'h00, 8'hFF});
      add_directed('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      add_directed('{8'h80, 8'h01, 8'h7F, 8'hFE});
      add_pause();

      // A full store, then blocks one and several bytes too long, then a short one.
      add_block(MAX_BYTES, FILL_RANDOM, 1'b0);
      add_block(MAX_BYTES + 1, FILL_RANDOM, 1'b0);
      add_pause();
      add_block(MAX_BYTES + 7, FILL_EDGE, 1'b0);
      add_block(3, FILL_RANDOM, 1'b1);

      bytes_queued = 0;
      idle_on = 1'b0;
      while (bytes_queued < RANDOM_BYTES) begin
         if ($urandom_range(0, 7) == 0) idle_on = ~idle_on;
         pick = $urandom_range(0, 9);
         if (pick < 6)      len = $urandom_range(1, 8);
         else if (pick < 9) len = $urandom_range(9, 40);
         else               len = $urandom_range(41, 200);
         pick = $urandom_range(0, 5);
         fill = (pick < 4) ? FILL_RANDOM : (pick == 4) ? FILL_SAME : FILL_EDGE;
         add_block(len, fill, idle_on);
         if ($urandom_range(0, 9) == 0) add_pause();
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!stalled && (byte_q.size() != 0 || start || checksum_q.size() != 0))
         @(posedge clock);
      if (!stalled) repeat (TAIL_CYCLES) @(posedge clock);

      if (!stalled && mismatches == 0 && checksum_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
